@@ rtl/drlm_pkg.sv @@
// Package for the decimated RMS level meter.
// Holds the item structs, the sequencer states and the datapath widths.
// No dependencies.
package drlm_pkg;

  // Fixed field widths.
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned STEP_W   = 16;
  localparam int unsigned LEVEL_W  = 16;
  localparam int unsigned COUNT_W  = 17;
  localparam int unsigned SQ_W     = 31;
  localparam int unsigned SUM_W    = 47;

  // Work register holds the dividend, then the quotient as radicand.
  localparam int unsigned WORK_W     = SUM_W + 1;
  localparam int unsigned DIV_STEPS  = SUM_W;
  localparam int unsigned SQRT_STEPS = WORK_W / 2;
  localparam int unsigned ROOT_W     = SQRT_STEPS;
  localparam int unsigned SUB_W      = ROOT_W + 2;
  localparam int unsigned STEPCNT_W  = $clog2(DIV_STEPS);

  // Largest number of samples that enter one mean.
  localparam logic [COUNT_W-1:0] KEPT_CAP = 17'd65536;
  localparam logic [SUM_W-1:0]   SUM_MAX  = {SUM_W{1'b1}};

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] rms_level;
    logic [COUNT_W-1:0] taken_count;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_DIV,
    ST_SQRT,
    ST_OUT
  } state_e;

endpackage

@@ rtl/drlm_sub.sv @@
// Shared subtract-and-compare unit of the level meter.
// Serves both the restoring divider and the digit-by-digit square root.
// Depends on drlm_pkg.
module drlm_sub (
  input  logic [drlm_pkg::SUB_W-1:0] a_i,
  input  logic [drlm_pkg::SUB_W-1:0] b_i,
  output logic [drlm_pkg::SUB_W-1:0] diff_o,
  output logic                       ge_o
);
  import drlm_pkg::*;

  logic [SUB_W:0] wide;

  assign wide   = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = wide[SUB_W-1:0];
  assign ge_o   = ~wide[SUB_W];

endmodule

@@ rtl/decimated_rms_level_meter.sv @@
// Top level of the decimated RMS level meter.
// Holds the sequencer, the accumulator and the divide and square-root registers.
// Depends on drlm_pkg and drlm_sub.
//
// Usage: audio samples enter on the input channel (valid/ready), one sample per
// item, and the last flag closes a buffer. Starting at the first sample of a
// buffer, every decimation_step-th sample is kept (a step of zero acts as one).
// The squares of the kept samples are summed, saturating at 2^47 - 1, and counted
// up to 65536 samples. On the item that carries last, one result item appears on
// the output channel: floor(sqrt(floor(sum / count))) and the count. Then the
// sum, the count and the stride position start over.
// Sequence: every item passes through accept, square and accumulate, and the
// input channel takes no new item until the block is back in its idle state.
// A closing item goes on to restoring division and then square root, both on
// the one shared subtractor, and ends with the load of the output register.
// The output register holds a result while the receiver stalls; new items are
// still taken meanwhile, and only a second result waits until the first is gone.
// Reset clears the sum, the count, the stride position and the output valid, and
// sets the step to one. The step register is written by cfg_we_i at any edge.
module decimated_rms_level_meter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [drlm_pkg::STEP_W-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  drlm_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output drlm_pkg::out_item_t           out_item_o
);
  import drlm_pkg::*;

  state_e state_q, state_d;

  // Configuration and stride tracking.
  logic [STEP_W-1:0]    step_q;
  logic [STEP_W-1:0]    phase_q;
  logic [STEP_W-1:0]    step_eff;
  logic [STEP_W:0]      phase_inc;

  // Captured item and accumulation state.
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       last_q;
  logic                       keep_q;
  logic [SQ_W-1:0]            sq_q;
  logic [SUM_W-1:0]           sum_q;
  logic [COUNT_W-1:0]         kept_q;
  logic [COUNT_W-1:0]         hold_q;

  logic [COUNT_W-1:0]   mag_ext;
  logic [COUNT_W-1:0]   mag;
  logic [2*COUNT_W-1:0] mag_sq;
  logic [SUM_W:0]       sum_wide;
  logic [SUM_W-1:0]     sum_new;
  logic [COUNT_W-1:0]   kept_new;
  logic [COUNT_W-1:0]   divisor;

  // Iterative divide and square-root state.
  logic [WORK_W-1:0]    work_q;
  logic [SUB_W-1:0]     rem_q;
  logic [ROOT_W-1:0]    root_q;
  logic [STEPCNT_W-1:0] cnt_q;
  logic                 div_done;
  logic                 sqrt_done;

  logic [SUB_W-1:0]     sub_a;
  logic [SUB_W-1:0]     sub_b;
  logic [SUB_W-1:0]     sub_diff;
  logic                 sub_ge;

  // Output register.
  logic      out_valid_q;
  out_item_t out_q;
  logic      out_load;

  logic in_accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign step_eff  = (step_q == '0) ? STEP_W'(1) : step_q;
  assign phase_inc = {1'b0, phase_q} + (STEP_W+1)'(1);

  // Magnitude of the held sample; the most negative value maps to 32768.
  assign mag_ext = {sample_q[SAMPLE_W-1], sample_q};
  assign mag     = sample_q[SAMPLE_W-1] ? (~mag_ext + COUNT_W'(1)) : mag_ext;
  assign mag_sq  = mag * mag;

  // Saturating accumulation of a kept square.
  assign sum_wide = {1'b0, sum_q} + (SUM_W+1)'(sq_q);
  assign sum_new  = !keep_q ? sum_q : (sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0]);
  assign kept_new = keep_q ? (kept_q + COUNT_W'(1)) : kept_q;

  assign divisor   = (hold_q == '0) ? COUNT_W'(1) : hold_q;
  assign div_done  = (cnt_q == STEPCNT_W'(DIV_STEPS - 1));
  assign sqrt_done = (cnt_q == STEPCNT_W'(SQRT_STEPS - 1));

  // Operand selection for the shared subtractor. The divider brings down one
  // dividend bit next to the partial remainder; the square root brings down two
  // radicand bits and tries the current root with 01 appended.
  always_comb begin
    if (state_q == ST_SQRT) begin
      sub_a = {rem_q[SUB_W-3:0], work_q[WORK_W-1:WORK_W-2]};
      sub_b = {root_q, 2'b01};
    end else begin
      sub_a = SUB_W'({rem_q[COUNT_W-1:0], work_q[SUM_W-1]});
      sub_b = SUB_W'(divisor);
    end
  end

  drlm_sub u_sub (
    .a_i    (sub_a),
    .b_i    (sub_b),
    .diff_o (sub_diff),
    .ge_o   (sub_ge)
  );

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) state_d = ST_SQUARE;
      end
      ST_SQUARE: state_d = ST_ACCUM;
      ST_ACCUM: begin
        state_d = last_q ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (div_done) state_d = ST_SQRT;
      end
      ST_SQRT: begin
        if (sqrt_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state: step register, stride position, running sum and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_W'(1);
      phase_q     <= '0;
      sum_q       <= '0;
      kept_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        step_q <= cfg_wdata_i;
      end
      if (in_accept) begin
        if (in_item_i.last || phase_inc >= {1'b0, step_eff}) begin
          phase_q <= '0;
        end else begin
          phase_q <= phase_inc[STEP_W-1:0];
        end
      end
      if (state_q == ST_ACCUM) begin
        // A closing item hands the totals to the divider and starts over.
        sum_q  <= last_q ? '0 : sum_new;
        kept_q <= last_q ? '0 : kept_new;
        cnt_q  <= '0;
      end
      if (state_q == ST_DIV || state_q == ST_SQRT) begin
        cnt_q <= (div_done && state_q == ST_DIV) ? '0 : cnt_q + STEPCNT_W'(1);
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // Payload and iteration registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sample_q <= in_item_i.sample;
      last_q   <= in_item_i.last;
      keep_q   <= (phase_q == '0) && (kept_q < KEPT_CAP);
    end
    if (state_q == ST_SQUARE) begin
      sq_q <= mag_sq[SQ_W-1:0];
    end
    if (state_q == ST_ACCUM) begin
      work_q <= {1'b0, sum_new};
      hold_q <= kept_new;
      rem_q  <= '0;
      root_q <= '0;
    end
    if (state_q == ST_DIV) begin
      // Quotient bits shift in at the bottom as dividend bits leave the top.
      work_q <= {1'b0, work_q[SUM_W-2:0], sub_ge};
      rem_q  <= div_done ? '0 : (sub_ge ? sub_diff : sub_a);
    end
    if (state_q == ST_SQRT) begin
      work_q <= {work_q[WORK_W-3:0], 2'b00};
      rem_q  <= sub_ge ? sub_diff : sub_a;
      root_q <= {root_q[ROOT_W-2:0], sub_ge};
    end
    if (out_load) begin
      out_q.rms_level   <= root_q[LEVEL_W-1:0];
      out_q.taken_count <= hold_q;
    end
  end

`ifndef SYNTHESIS
  // Every result covers at least the first sample of its buffer.
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.taken_count != '0))
    else $error("result with zero taken count");

  // The level of full-scale audio never exceeds 32768.
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.rms_level <= LEVEL_W'(32768)))
    else $error("rms level above full scale");

  // The block is busy for the cycle after it takes an item.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while previous item still in work");

  // A new result only appears out of the output-load state.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_OUT))
    else $error("result valid raised outside output load");
`endif

endmodule
